/* rtl/cce_pkg.sv */
// ----------------------------------------------------------------------------
// cce_pkg
// Types, constants and bit functions shared by the crc32 engine modules.
// ----------------------------------------------------------------------------
package cce_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] POLY_RESET = 32'h04C11DB7;
  localparam logic [31:0] INIT_RESET = 32'hFFFFFFFF;
  localparam logic [31:0] XOUT_RESET = 32'hFFFFFFFF;
  localparam logic        BIGE_RESET = 1'b0;

  typedef enum logic [1:0] {
    REG_POLYNOMIAL     = 2'd0,
    REG_INIT_VALUE     = 2'd1,
    REG_XOR_OUT        = 2'd2,
    REG_BIG_ENDIAN_OUT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
    logic       end_of_message;
  } crc_req_t;

  typedef struct packed {
    logic [31:0] running_crc;
    logic [31:0] final_crc;
    logic        message_done;
  } crc_res_t;

  // classified request as it waits between front and back
  typedef struct packed {
    logic       load_init;
    logic       last;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic [31:0] rpoly;
    logic [31:0] init_value;
    logic [31:0] xor_out;
    logic        big_endian_out;
  } crc_cfg_t;

  function automatic logic [31:0] reverse32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31 - i];
    end
    return r;
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // eight lsb-first shift steps of the reflected crc
  function automatic logic [31:0] absorb_byte(input logic [31:0] crc,
                                              input logic [7:0]  data,
                                              input logic [31:0] rpoly);
    logic [31:0] r;
    r = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ rpoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cce_front.sv */
// ----------------------------------------------------------------------------
// cce_front
// Accepts requests, classifies them into commands and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module cce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cce_pkg::crc_req_t request,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output cce_pkg::crc_cmd_t cmd
);

  cce_pkg::crc_cmd_t                  slots [cce_pkg::QUEUE_DEPTH];
  logic [cce_pkg::QPTR_W-1:0]         wr_ptr, wr_ptr_next;
  logic [cce_pkg::QPTR_W-1:0]         rd_ptr, rd_ptr_next;
  logic [cce_pkg::QCNT_W-1:0]         count, count_next;
  logic                               enq, deq;
  cce_pkg::crc_cmd_t                  new_cmd;

  assign full      = (count == cce_pkg::QCNT_W'(cce_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign enq       = push && !full;
  assign deq       = cmd_take && cmd_valid;

  always_comb begin
    new_cmd.load_init = request.start_of_message;
    new_cmd.last      = request.end_of_message;
    new_cmd.data      = request.data_byte;
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (enq) begin
      wr_ptr_next = (wr_ptr == cce_pkg::QPTR_W'(cce_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (deq) begin
      rd_ptr_next = (rd_ptr == cce_pkg::QPTR_W'(cce_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    unique case ({enq, deq})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cce_pkg::QCNT_W'(cce_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (enq && !deq) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a write");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_take) |=> $stable(rd_ptr))
    else $error("queue head moved without a take");

endmodule

/* rtl/cce_back.sv */
// ----------------------------------------------------------------------------
// cce_back
// Runs one byte per cycle, unless a result waits unpopped, through the
// reflected crc register; the result sits in an output register until popped.
// ----------------------------------------------------------------------------
module cce_back (
  input  logic              clk,
  input  logic              rst,
  input  cce_pkg::crc_cfg_t cfg,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  cce_pkg::crc_cmd_t cmd,
  output logic              empty,
  input  logic              pop,
  output cce_pkg::crc_res_t result
);

  logic [31:0]       crc, crc_next;
  logic              res_valid;
  cce_pkg::crc_res_t res_next;
  logic [31:0]       seed;
  logic [31:0]       fin;

  assign cmd_take = cmd_valid && (!res_valid || pop);
  assign empty    = !res_valid;

  always_comb begin
    seed     = cmd.load_init ? cfg.init_value : crc;
    crc_next = cce_pkg::absorb_byte(seed, cmd.data, cfg.rpoly);
    fin      = crc_next ^ cfg.xor_out;
    res_next.running_crc  = crc_next;
    res_next.final_crc    = cfg.big_endian_out ? cce_pkg::swap_bytes(fin) : fin;
    res_next.message_done = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= cce_pkg::INIT_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        crc       <= crc_next;
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      result <= res_next;
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> res_valid)
    else $error("taken command left no result");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd_take |=> $stable(crc))
    else $error("crc register changed without a command");

  a_running_match: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> result.running_crc == crc)
    else $error("result disagrees with crc register");

endmodule

/* rtl/configurable_crc32_engine_top.sv */
// ----------------------------------------------------------------------------
// configurable_crc32_engine_top
// Reflected crc-32 over a byte stream with programmable polynomial, initial
// value, final xor and output byte order.
//
//   channel   handshake             payload
//   request   push / full           request   (data_byte, start, end)
//   result    empty / pop           result    (running, final, done)
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per clock sustained unless a result waits unpopped
// a pushed request passes a queue slot and then the result register
// a two-entry command queue and the result register decouple the two sides
// full rises only when the queue holds two commands and the result is stalled
// reset puts the registers at their defaults and the crc register at all ones
// ----------------------------------------------------------------------------
module configurable_crc32_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cce_pkg::crc_req_t request,
  output logic              empty,
  input  logic              pop,
  output cce_pkg::crc_res_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  logic [31:0]       polynomial;
  logic [31:0]       init_value;
  logic [31:0]       xor_out;
  logic              big_endian_out;
  cce_pkg::crc_cfg_t cfg;
  cce_pkg::crc_cmd_t cmd;
  logic              cmd_valid;
  logic              cmd_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial     <= cce_pkg::POLY_RESET;
      init_value     <= cce_pkg::INIT_RESET;
      xor_out        <= cce_pkg::XOUT_RESET;
      big_endian_out <= cce_pkg::BIGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cce_pkg::cfg_reg_e'(cfg_index))
        cce_pkg::REG_POLYNOMIAL:     polynomial     <= cfg_data;
        cce_pkg::REG_INIT_VALUE:     init_value     <= cfg_data;
        cce_pkg::REG_XOR_OUT:        xor_out        <= cfg_data;
        cce_pkg::REG_BIG_ENDIAN_OUT: big_endian_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // engine shifts right, so it wants the polynomial lsb-first
  always_comb begin
    cfg.rpoly          = cce_pkg::reverse32(polynomial);
    cfg.init_value     = init_value;
    cfg.xor_out        = xor_out;
    cfg.big_endian_out = big_endian_out;
  end

  cce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  cce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
